// File: rtl/wrsp_pkg.sv
// ----------------------------------------------------------------------------
// wrsp_pkg
// Shared types and constants of the RIFF/WAVE byte stream parser.
// ----------------------------------------------------------------------------
package wrsp_pkg;

  // Largest sample size in bytes that the data path supports by default.
  localparam int MAX_SAMPLE_BYTES_DEF = 4;

  // Result queue geometry.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  // Packed width of the result word on the stream bus.
  localparam int OUT_TDATA_W = 120;

  // Tags as little-endian words of their four ASCII bytes.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE_LEN = 32'd44;
  localparam logic [31:0] MIN_FMT_LEN  = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_SHORT_FILE = 4'd0,
    ERR_NO_RIFF    = 4'd1,
    ERR_NO_WAVE    = 4'd2,
    ERR_FMT_SHORT  = 4'd3,
    ERR_NOT_PCM    = 4'd4,
    ERR_DATA_FIRST = 4'd5,
    ERR_NO_ROOM    = 4'd6,
    ERR_PAST_END   = 4'd7,
    ERR_BAD_DEPTH  = 4'd8
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] sample_value;
    logic [15:0]        channel_index;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [15:0]        sample_bits;
    logic [3:0]         error_code;
  } result_t;

  // Results produced by one byte: count is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t error_result(err_t code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t done_result();
    result_t r;
    r      = '0;
    r.kind = KIND_DONE;
    return r;
  endfunction

endpackage

// File: rtl/wav_riff_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_riff_stream_parser
// Streaming RIFF/WAVE PCM parser: takes the file one byte per word, checks
// the RIFF and WAVE tags, walks the chunks, reports the format and emits
// every sample as a sign-extended integer with its channel index.
//
//   Channel   Direction  Width  Contents
//   in_*      slave      8      tdata: data_byte
//   out_*     master     120/2  tdata: sample_value .. error_code, tuser: kind
//   cfg_*     slave      32     data: file_length
//
// One byte is taken per cycle while in_tready is high; its results are ready in the next cycle.
// Each byte yields up to two results, which enter a four-entry result queue;
// in_tready is high while the queue has room for two, so bytes flow at one
// per cycle as long as results drain at one per cycle.
// cfg_ready is always high. Reset is synchronous, active low, and returns
// the parser to the RIFF tag; an error or end of file halts it until reset.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser #(
  parameter int MAX_SAMPLE_BYTES = wrsp_pkg::MAX_SAMPLE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [31:0]                      cfg_data,   // file_length
  // Byte input.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  // Result output.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] sample_value, [47:32] channel_index, [63:48] channel_count,
  // [95:64] sample_rate, [111:96] sample_bits, [115:112] error_code
  output logic [wrsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                       out_tuser   // [1:0] result_kind
);

  wrsp_pkg::push_t   push;
  wrsp_pkg::result_t res;
  logic              room;
  logic              in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  // Parse step.
  wrsp_core #(
    .MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_acc),
    .in_data  (in_tdata),
    .push     (push)
  );

  // Result queue.
  wrsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result word.
  assign out_tdata = {4'd0, res.error_code, res.sample_bits, res.sample_rate,
                      res.channel_count, res.channel_index, res.sample_value};
  assign out_tuser = res.kind;

endmodule

// File: rtl/wrsp_core.sv
// ----------------------------------------------------------------------------
// wrsp_core
// Per-byte parse step: holds the parser state and turns each accepted byte
// into zero, one or two results, combinationally.
// ----------------------------------------------------------------------------
module wrsp_core #(
  parameter int MAX_SAMPLE_BYTES = wrsp_pkg::MAX_SAMPLE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  input  logic [7:0]      in_data,
  output wrsp_pkg::push_t push
);

  localparam int ACC_W = 8 * MAX_SAMPLE_BYTES;
  localparam int BIS_W = (MAX_SAMPLE_BYTES > 1) ? $clog2(MAX_SAMPLE_BYTES) : 1;
  localparam logic [12:0] MAX_BYTES_C = 13'(MAX_SAMPLE_BYTES);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_HEADER,
    PH_FMT,
    PH_DATA,
    PH_SKIP
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        flen_r;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        tag_r, tag_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic               fmt_seen_r, fmt_seen_nxt;
  logic [15:0]        fmt_tag_r, fmt_tag_nxt;
  logic [15:0]        chan_r, chan_nxt;
  logic [31:0]        rate_r, rate_nxt;
  logic [15:0]        bits_r, bits_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [BIS_W-1:0]   bis_r, bis_nxt;
  logic [15:0]        ch_r, ch_nxt;
  logic               halted_r, halted_nxt;
  logic [3:0]         fo_r, fo_nxt;

  logic [32:0]        next33;
  logic               end_reached;
  logic               hdr_no_room;
  logic [31:0]        rem_dec;
  logic [31:0]        rem_full;
  logic [31:0]        tag_full;
  logic [33:0]        body_end_sum;
  logic [15:0]        bits_full;
  logic [31:0]        acc32;
  logic [31:0]        samp_val;
  logic [16:0]        ch_inc;
  logic [2:0]         hdr_off;

  logic               err_hit;
  wrsp_pkg::err_t     err_code;
  logic               samp_hit;
  logic               fmt_hit;
  logic               done_hit;
  wrsp_pkg::result_t  primary;

  // Arithmetic shared by several phases.
  assign next33       = {1'b0, pos_r} + 33'd1;
  assign end_reached  = next33 >= {1'b0, flen_r};
  assign hdr_no_room  = ({1'b0, pos_r} + 33'd8) >= {1'b0, flen_r};
  assign rem_dec      = rem_r - 32'd1;
  assign rem_full     = {in_data, rem_r[23:0]};
  assign tag_full     = {in_data, tag_r[23:0]};
  assign body_end_sum = {1'b0, next33} + {2'b00, rem_full};
  assign bits_full    = {in_data, bits_r[7:0]};
  assign acc32        = 32'(acc_r);
  assign ch_inc       = {1'b0, ch_r} + 17'd1;
  assign hdr_off      = fo_r[2:0];

  // Sample assembly: lanes below the current one come from the accumulator,
  // the current lane is the incoming byte, and lanes above carry its sign.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < int'(bis_r)) begin
        samp_val[8*k +: 8] = acc32[8*k +: 8];
      end else if (k == int'(bis_r)) begin
        samp_val[8*k +: 8] = in_data;
      end else begin
        samp_val[8*k +: 8] = {8{in_data[7]}};
      end
    end
  end

  // Parse step for one accepted byte.
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    rem_nxt      = rem_r;
    fmt_seen_nxt = fmt_seen_r;
    fmt_tag_nxt  = fmt_tag_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    acc_nxt      = acc_r;
    bis_nxt      = bis_r;
    ch_nxt       = ch_r;
    halted_nxt   = halted_r;
    fo_nxt       = fo_r;
    err_hit      = 1'b0;
    err_code     = wrsp_pkg::ERR_SHORT_FILE;
    samp_hit     = 1'b0;
    fmt_hit      = 1'b0;
    done_hit     = 1'b0;

    if (in_valid && !halted_r) begin
      pos_nxt = next33[31:0];
      unique case (phase_r)
        // RIFF tag, size word and WAVE tag.
        PH_RIFF: begin
          priority if (pos_r == 32'd0 && flen_r < wrsp_pkg::MIN_FILE_LEN) begin
            err_hit  = 1'b1;
            err_code = wrsp_pkg::ERR_SHORT_FILE;
          end else if (pos_r < 32'd4 &&
                       in_data != wrsp_pkg::TAG_RIFF[8*pos_r[1:0] +: 8]) begin
            err_hit  = 1'b1;
            err_code = wrsp_pkg::ERR_NO_RIFF;
          end else if (pos_r >= 32'd8 && pos_r < 32'd12 &&
                       in_data != wrsp_pkg::TAG_WAVE[8*pos_r[1:0] +: 8]) begin
            err_hit  = 1'b1;
            err_code = wrsp_pkg::ERR_NO_WAVE;
          end else if (pos_r >= 32'd11) begin
            phase_nxt = PH_HEADER;
            fo_nxt    = 4'd0;
          end else begin
            phase_nxt = PH_RIFF;
          end
        end

        // Chunk header: four tag bytes then four size bytes.
        PH_HEADER: begin
          priority if (hdr_off == 3'd0 && hdr_no_room) begin
            err_hit  = 1'b1;
            err_code = wrsp_pkg::ERR_NO_ROOM;
          end else if (hdr_off == 3'd3 && tag_full == wrsp_pkg::TAG_DATA && !fmt_seen_r) begin
            err_hit  = 1'b1;
            err_code = wrsp_pkg::ERR_DATA_FIRST;
          end else begin
            fo_nxt = {1'b0, hdr_off + 3'd1};
            if (hdr_off == 3'd0) begin
              tag_nxt = {24'd0, in_data};
              rem_nxt = 32'd0;
            end else if (!hdr_off[2]) begin
              tag_nxt[8*hdr_off[1:0] +: 8] = in_data;
            end else begin
              rem_nxt[8*hdr_off[1:0] +: 8] = in_data;
            end
            if (hdr_off == 3'd7) begin
              fo_nxt = 4'd0;
              priority if (tag_r == wrsp_pkg::TAG_FMT) begin
                priority if (body_end_sum >= {2'b00, flen_r}) begin
                  err_hit  = 1'b1;
                  err_code = wrsp_pkg::ERR_PAST_END;
                end else if (rem_full < wrsp_pkg::MIN_FMT_LEN) begin
                  err_hit  = 1'b1;
                  err_code = wrsp_pkg::ERR_FMT_SHORT;
                end else begin
                  fmt_tag_nxt = 16'd0;
                  chan_nxt    = 16'd0;
                  rate_nxt    = 32'd0;
                  bits_nxt    = 16'd0;
                  phase_nxt   = PH_FMT;
                end
              end else if (tag_r == wrsp_pkg::TAG_DATA) begin
                if (body_end_sum > {2'b00, flen_r}) begin
                  err_hit  = 1'b1;
                  err_code = wrsp_pkg::ERR_PAST_END;
                end else begin
                  acc_nxt   = '0;
                  bis_nxt   = '0;
                  ch_nxt    = 16'd0;
                  phase_nxt = (rem_full == 32'd0) ? PH_HEADER : PH_DATA;
                end
              end else begin
                // Unknown chunk; an empty one ends at once.
                phase_nxt = PH_SKIP;
                if (rem_full == 32'd0) begin
                  if (end_reached) begin
                    done_hit = 1'b1;
                  end else begin
                    phase_nxt = PH_HEADER;
                  end
                end
              end
            end
          end
        end

        // First sixteen bytes of a format chunk.
        PH_FMT: begin
          rem_nxt = rem_dec;
          fo_nxt  = fo_r + 4'd1;
          if (fo_r < 4'd2) begin
            fmt_tag_nxt[8*fo_r[0] +: 8] = in_data;
          end else if (fo_r < 4'd4) begin
            chan_nxt[8*fo_r[0] +: 8] = in_data;
          end else if (fo_r < 4'd8) begin
            rate_nxt[8*fo_r[1:0] +: 8] = in_data;
          end else if (fo_r >= 4'd14) begin
            bits_nxt[8*fo_r[0] +: 8] = in_data;
          end
          if (fo_r == 4'd15) begin
            fo_nxt = 4'd0;
            priority if (fmt_tag_r != wrsp_pkg::FMT_PCM) begin
              err_hit  = 1'b1;
              err_code = wrsp_pkg::ERR_NOT_PCM;
            end else if (bits_full == 16'd0 || bits_full[2:0] != 3'd0 ||
                         bits_full[15:3] > MAX_BYTES_C) begin
              err_hit  = 1'b1;
              err_code = wrsp_pkg::ERR_BAD_DEPTH;
            end else begin
              fmt_seen_nxt = 1'b1;
              fmt_hit      = 1'b1;
              phase_nxt    = PH_SKIP;
              if (rem_dec == 32'd0) begin
                if (end_reached) begin
                  done_hit = 1'b1;
                end else begin
                  phase_nxt = PH_HEADER;
                end
              end
            end
          end
        end

        // Sample bytes, little-endian, channels interleaved.
        PH_DATA: begin
          rem_nxt = rem_dec;
          if (chan_r != 16'd0) begin
            if ((4'(bis_r) + 4'd1) >= {1'b0, bits_r[5:3]}) begin
              samp_hit = 1'b1;
              acc_nxt  = '0;
              bis_nxt  = '0;
              ch_nxt   = (ch_inc >= {1'b0, chan_r}) ? 16'd0 : ch_inc[15:0];
            end else begin
              acc_nxt[8*bis_r +: 8] = in_data;
              bis_nxt = bis_r + 1'b1;
            end
          end
          if (rem_dec == 32'd0) begin
            if (end_reached) begin
              done_hit = 1'b1;
            end else begin
              phase_nxt = PH_HEADER;
              fo_nxt    = 4'd0;
            end
          end
        end

        // Unknown chunk body or trailing format bytes.
        PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0 || end_reached) begin
            if (end_reached) begin
              done_hit = 1'b1;
            end else begin
              phase_nxt = PH_HEADER;
              fo_nxt    = 4'd0;
            end
          end
        end

        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Result selection: an error stands alone; otherwise a sample or format
  // result goes first and the end-of-file result follows it.
  always_comb begin
    primary = '0;
    if (samp_hit) begin
      primary.kind          = wrsp_pkg::KIND_SAMPLE;
      primary.sample_value  = samp_val;
      primary.channel_index = ch_r;
    end else begin
      primary.kind          = wrsp_pkg::KIND_FORMAT;
      primary.channel_count = chan_r;
      primary.sample_rate   = rate_r;
      primary.sample_bits   = bits_full;
    end

    push = '0;
    if (err_hit) begin
      push.count = 2'd1;
      push.first = wrsp_pkg::error_result(err_code);
    end else if (samp_hit || fmt_hit) begin
      push.first = primary;
      if (done_hit) begin
        push.count  = 2'd2;
        push.second = wrsp_pkg::done_result();
      end else begin
        push.count = 2'd1;
      end
    end else if (done_hit) begin
      push.count = 2'd1;
      push.first = wrsp_pkg::done_result();
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      flen_r     <= 32'd0;
      pos_r      <= 32'd0;
      tag_r      <= 32'd0;
      rem_r      <= 32'd0;
      fmt_seen_r <= 1'b0;
      fmt_tag_r  <= 16'd0;
      chan_r     <= 16'd0;
      rate_r     <= 32'd0;
      bits_r     <= 16'd0;
      acc_r      <= '0;
      bis_r      <= '0;
      ch_r       <= 16'd0;
      halted_r   <= 1'b0;
      fo_r       <= 4'd0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      tag_r      <= tag_nxt;
      rem_r      <= rem_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      fmt_tag_r  <= fmt_tag_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      acc_r      <= acc_nxt;
      bis_r      <= bis_nxt;
      ch_r       <= ch_nxt;
      halted_r   <= halted_nxt || err_hit || done_hit;
      fo_r       <= fo_nxt;
      if (cfg_we) begin
        flen_r <= cfg_data;
      end
    end
  end

  // Once halted the parser stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("parser left the halted state");

  // A halted parser produces nothing.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> push.count == 2'd0)
    else $error("result produced while halted");

  // An error result halts the parser.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0 && push.first.kind == wrsp_pkg::KIND_ERROR) |=> halted_r)
    else $error("error result without halt");

  // A second result from one byte is always the end-of-file result.
  a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |-> (push.second.kind == wrsp_pkg::KIND_DONE &&
                            push.first.kind != wrsp_pkg::KIND_ERROR))
    else $error("bad result pair");

endmodule

// File: rtl/wrsp_out_fifo.sv
// ----------------------------------------------------------------------------
// wrsp_out_fifo
// Small result queue that takes up to two results per cycle and hands one
// result per cycle to the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module wrsp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  wrsp_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output wrsp_pkg::result_t out_res
);

  localparam int PTR_W = wrsp_pkg::OUT_PTR_W;
  localparam logic [PTR_W:0] ROOM_MAX  = (PTR_W + 1)'(wrsp_pkg::OUT_DEPTH - 2);
  localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(wrsp_pkg::OUT_DEPTH);

  wrsp_pkg::result_t mem_r [wrsp_pkg::OUT_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [PTR_W:0]    cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  wr_p1;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_r];
  assign room      = cnt_r <= ROOM_MAX;
  assign wr_p1     = wr_r + 1'b1;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.count);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_p1] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("result queue overflow");

  a_pair_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> cnt_r <= ROOM_MAX)
    else $error("push without room for two results");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r - rd_r) == cnt_r[PTR_W-1:0])
    else $error("queue pointers disagree with fill count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd3)
    else $error("illegal push count");

endmodule

// File: tb/sv/wav_stream_checker.sv
// ----------------------------------------------------------------------------
// wav_stream_checker
// Watches the configuration, byte and result channels of the WAV parser.
// It keeps its own model of the parse, predicts the results of every
// accepted byte and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module wav_stream_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           failures,
  output int           pending,
  output int           samples_checked,
  output int           formats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Where the parse stands in the file.
  typedef enum logic [2:0] {
    STAGE_RIFF,
    STAGE_HEADER,
    STAGE_FMT,
    STAGE_DATA,
    STAGE_SKIP
  } stage_t;

  // Predicted parser state.
  logic [31:0] length_reg;
  logic [31:0] position;
  stage_t      stage;
  logic [31:0] tag_word;
  logic [31:0] body_left;
  logic        have_format;
  logic [15:0] fmt_code;
  logic [15:0] n_channels;
  logic [31:0] rate;
  logic [15:0] depth;
  logic [31:0] accum;
  logic [2:0]  acc_bytes;
  logic [15:0] channel;
  logic        stopped;
  logic [4:0]  field_pos;

  wrsp_pkg::result_t expected_results[$];
  int                mismatch_count = 0;
  int                sample_total   = 0;
  int                format_total   = 0;

  task automatic clear_state();
    length_reg  = '0;
    position    = '0;
    stage       = STAGE_RIFF;
    tag_word    = '0;
    body_left   = '0;
    have_format = 1'b0;
    fmt_code    = '0;
    n_channels  = '0;
    rate        = '0;
    depth       = '0;
    accum       = '0;
    acc_bytes   = '0;
    channel     = '0;
    stopped     = 1'b0;
    field_pos   = '0;
    expected_results.delete();
  endtask

  // Appends one predicted result word at the tail of the queue.
  task automatic expect_word(input wrsp_pkg::result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic halt_with(input wrsp_pkg::err_t code);
    wrsp_pkg::result_t r;
    r            = '0;
    r.kind       = wrsp_pkg::KIND_ERROR;
    r.error_code = code;
    stopped      = 1'b1;
    expect_word(r);
  endtask

  // End of a chunk body: either the file ends here or the next header follows.
  // Unknown chunks and skipped fmt bytes also end early at the end of the file.
  task automatic finish_body(input logic [63:0] at, input bit unknown);
    wrsp_pkg::result_t r;
    if (body_left == 0 || (unknown && at >= length_reg)) begin
      if (at >= length_reg) begin
        r       = '0;
        r.kind  = wrsp_pkg::KIND_DONE;
        stopped = 1'b1;
        expect_word(r);
      end else begin
        stage     = STAGE_HEADER;
        field_pos = '0;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [63:0]       here;
    logic [63:0]       after;
    logic [2:0]        o;
    logic [3:0]        f;
    logic [1:0]        j;
    logic [31:0]       v;
    logic [31:0]       mask;
    wrsp_pkg::result_t r;
    if (stopped) return;
    here     = {32'd0, position};
    after    = here + 64'd1;
    position = after[31:0];

    case (stage)
      // File tags; the RIFF size word is not looked at.
      STAGE_RIFF: begin
        if (here == 0 && length_reg < wrsp_pkg::MIN_FILE_LEN) begin
          halt_with(wrsp_pkg::ERR_SHORT_FILE);
          return;
        end
        if (here < 4 && b != wrsp_pkg::TAG_RIFF[8*here[1:0] +: 8]) begin
          halt_with(wrsp_pkg::ERR_NO_RIFF);
          return;
        end
        if (here >= 8 && here < 12 && b != wrsp_pkg::TAG_WAVE[8*here[1:0] +: 8]) begin
          halt_with(wrsp_pkg::ERR_NO_WAVE);
          return;
        end
        if (here >= 11) begin
          stage     = STAGE_HEADER;
          field_pos = '0;
        end
      end

      // Chunk header: tag then little-endian size.
      STAGE_HEADER: begin
        o = field_pos[2:0];
        if (o == 0) begin
          if (here + 64'd8 >= length_reg) begin
            halt_with(wrsp_pkg::ERR_NO_ROOM);
            return;
          end
          tag_word  = '0;
          body_left = '0;
        end
        if (o < 4) begin
          tag_word[8*o[1:0] +: 8] = b;
          if (o == 3 && tag_word == wrsp_pkg::TAG_DATA && !have_format) begin
            halt_with(wrsp_pkg::ERR_DATA_FIRST);
            return;
          end
        end else begin
          body_left[8*o[1:0] +: 8] = b;
        end
        field_pos = {2'b00, o} + 5'd1;
        if (o < 7) return;
        field_pos = '0;
        if (tag_word == wrsp_pkg::TAG_FMT) begin
          if (after + body_left >= length_reg) begin
            halt_with(wrsp_pkg::ERR_PAST_END);
            return;
          end
          if (body_left < wrsp_pkg::MIN_FMT_LEN) begin
            halt_with(wrsp_pkg::ERR_FMT_SHORT);
            return;
          end
          fmt_code   = '0;
          n_channels = '0;
          rate       = '0;
          depth      = '0;
          stage      = STAGE_FMT;
        end else if (tag_word == wrsp_pkg::TAG_DATA) begin
          if (after + body_left > length_reg) begin
            halt_with(wrsp_pkg::ERR_PAST_END);
            return;
          end
          accum     = '0;
          acc_bytes = '0;
          channel   = '0;
          stage     = (body_left == 0) ? STAGE_HEADER : STAGE_DATA;
        end else begin
          stage = STAGE_SKIP;
          if (body_left == 0) finish_body(after, 1'b1);
        end
      end

      // First 16 bytes of fmt: tag, channels, rate, two ignored fields, bits.
      STAGE_FMT: begin
        f         = field_pos[3:0];
        body_left = body_left - 32'd1;
        if (f < 2)       fmt_code[8*f[0] +: 8]   = b;
        else if (f < 4)  n_channels[8*f[0] +: 8] = b;
        else if (f < 8)  rate[8*f[1:0] +: 8]     = b;
        else if (f >= 14) depth[8*f[0] +: 8]     = b;
        field_pos = {1'b0, f} + 5'd1;
        if (f < 15) return;
        field_pos = '0;
        if (fmt_code != wrsp_pkg::FMT_PCM) begin
          halt_with(wrsp_pkg::ERR_NOT_PCM);
          return;
        end
        if (depth == 0 || depth[2:0] != 0 ||
            depth / 8 > wrsp_pkg::MAX_SAMPLE_BYTES_DEF) begin
          halt_with(wrsp_pkg::ERR_BAD_DEPTH);
          return;
        end
        have_format     = 1'b1;
        r               = '0;
        r.kind          = wrsp_pkg::KIND_FORMAT;
        r.channel_count = n_channels;
        r.sample_rate   = rate;
        r.sample_bits   = depth;
        expect_word(r);
        stage = STAGE_SKIP;
        finish_body(after, 1'b0);
      end

      // Sample bytes, little endian, sign-extended from the bit depth.
      STAGE_DATA: begin
        body_left = body_left - 32'd1;
        if (n_channels != 0) begin
          j         = acc_bytes[1:0];
          accum     = accum | ({24'd0, b} << (8 * j));
          acc_bytes = {1'b0, j} + 3'd1;
          if (acc_bytes >= depth / 8) begin
            v = accum;
            if (depth < 32 && depth > 0) begin
              mask = (32'd1 << depth) - 32'd1;
              v    = v & mask;
              if (v[depth - 1]) v = v | ~mask;
            end
            r               = '0;
            r.kind          = wrsp_pkg::KIND_SAMPLE;
            r.sample_value  = v;
            r.channel_index = channel;
            expect_word(r);
            accum     = '0;
            acc_bytes = '0;
            channel   = channel + 16'd1;
            if (channel >= n_channels) channel = '0;
          end
        end
        finish_body(after, 1'b0);
      end

      default: begin
        body_left = body_left - 32'd1;
        finish_body(after, 1'b1);
      end
    endcase
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    wrsp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("result word of kind %0d arrived with nothing expected", out_tuser);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind",   32'(want.kind),          32'(out_tuser));
    compare_field("sample_value",  32'(want.sample_value),  out_tdata[31:0]);
    compare_field("channel_index", 32'(want.channel_index), 32'(out_tdata[47:32]));
    compare_field("channel_count", 32'(want.channel_count), 32'(out_tdata[63:48]));
    compare_field("sample_rate",   want.sample_rate,        out_tdata[95:64]);
    compare_field("sample_bits",   32'(want.sample_bits),   32'(out_tdata[111:96]));
    compare_field("error_code",    32'(want.error_code),    32'(out_tdata[115:112]));
    if (want.kind == wrsp_pkg::KIND_SAMPLE) sample_total++;
    if (want.kind == wrsp_pkg::KIND_FORMAT) format_total++;
  endtask

  // All three channels are sampled at the rising edge. A byte taken at the
  // same edge as a length write still sees the old length.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) parse_byte(in_tdata);
      if (cfg_valid && cfg_ready) length_reg = cfg_data;
    end
    pending         <= expected_results.size();
    failures        <= mismatch_count;
    samples_checked <= sample_total;
    formats_checked <= format_total;
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams one long WAV file into the parser: a fixed opening with extreme
// format and sample values, then random fmt, data and unknown chunks with
// length rewrites between chunks, then a randomly chosen ending that halts
// the parse, followed by bytes that must be ignored.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TARGET_BYTES = 830;

  // Ways the file can end.
  typedef enum int {
    END_DONE_SKIP,
    END_DONE_DATA,
    END_NO_ROOM,
    END_FMT_PAST,
    END_FMT_SHORT,
    END_NOT_PCM,
    END_BAD_DEPTH,
    END_DATA_PAST
  } ending_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data   = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;

  int failures;
  int pending;
  int samples_checked;
  int formats_checked;

  int      cycle_count    = 0;
  int      bytes_accepted = 0;
  int      send_idle_pct  = 0;
  int      stall_pct      = 0;
  int      held_bytes     = 1;
  ending_t ending;

  wav_riff_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  wav_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .failures        (failures),
    .pending         (pending),
    .samples_checked (samples_checked),
    .formats_checked (formats_checked)
  );

  always #5 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side backpressure.
  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
  end

  // Sends one word; called and returning at a falling edge.
  // The idling phase rotates with the byte count.
  task automatic send_byte(input logic [7:0] b);
    case ((bytes_accepted / 64) % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 57; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 57; end
      default: begin send_idle_pct = 17; stall_pct = 17; end
    endcase
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_accepted++;
  endtask

  task automatic send_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  task automatic send_header(input logic [31:0] tag, input logic [31:0] size);
    send_le(tag, 4);
    send_le(size, 4);
  endtask

  // Complete fmt chunk; byte rate and block align carry random values.
  task automatic send_fmt(input logic [15:0] code, input logic [15:0] chans,
                          input logic [31:0] sps, input logic [15:0] bits, input int extra);
    send_header(wrsp_pkg::TAG_FMT, 32'(16 + extra));
    send_le(32'(code), 2);
    send_le(32'(chans), 2);
    send_le(sps, 4);
    send_le($urandom, 4);
    send_le($urandom, 2);
    send_le(32'(bits), 2);
    send_noise(extra);
  endtask

  // Stop sending until every expected result is out, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Main stimulus.
  initial begin
    logic [31:0] tag;
    logic [31:0] length;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] sps;
    int          n;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Opening: smallest legal file length while the tags go in.
    write_length(32'd0);
    write_length(wrsp_pkg::MIN_FILE_LEN);
    send_header(wrsp_pkg::TAG_RIFF, $urandom);
    send_le(wrsp_pkg::TAG_WAVE, 4);
    drain();
    write_length(32'hFFFF_FFFF);

    // Widest format values with one extra fmt byte, then 8-bit extremes
    // and a trailing sample for the next channel.
    send_fmt(wrsp_pkg::FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'd8, 1);
    held_bytes = 1;
    send_header(wrsp_pkg::TAG_DATA, 32'd5);
    send_le(32'hFF80_7F00, 4);
    send_byte(8'h01);

    // Random chunks.
    while (bytes_accepted < TARGET_BYTES) begin
      n = $urandom_range(0, 19);
      if (n < 10) begin
        n = $urandom_range(0, 48);
        send_header(wrsp_pkg::TAG_DATA, 32'(n));
        send_noise(n);
      end else if (n < 13) begin
        case ($urandom_range(0, 7))
          0:       chans = 16'd0;
          1:       chans = 16'hFFFF;
          2:       chans = 16'($urandom);
          default: chans = 16'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
          0:       sps = 32'd0;
          1:       sps = 32'hFFFF_FFFF;
          default: sps = $urandom;
        endcase
        held_bytes = $urandom_range(1, wrsp_pkg::MAX_SAMPLE_BYTES_DEF);
        send_fmt(wrsp_pkg::FMT_PCM, chans, sps, 16'(8 * held_bytes),
                 $urandom_range(0, 5));
      end else if (n < 18) begin
        do tag = $urandom; while (tag == wrsp_pkg::TAG_FMT || tag == wrsp_pkg::TAG_DATA);
        n = $urandom_range(0, 16);
        send_header(tag, 32'(n));
        send_noise(n);
      end else begin
        drain();
        if ($urandom_range(0, 1))
          write_length(32'hFFFF_FFFF);
        else
          write_length($urandom_range(32'hFFFF_FFFF, bytes_accepted + 4096));
      end
    end

    // Ending that halts the parse; lengths, where written, are set relative to the position or to zero.
    drain();
    ending = ending_t'($urandom_range(0, 7));
    case (ending)
      END_DONE_SKIP: begin
        n = $urandom_range(1, 20);
        write_length(32'(bytes_accepted + 8 + n));
        do tag = $urandom; while (tag == wrsp_pkg::TAG_FMT || tag == wrsp_pkg::TAG_DATA);
        send_header(tag, 32'(n + $urandom_range(0, 50)));
        send_noise(n);
      end
      END_DONE_DATA: begin
        // Last sample and end of file land on the same byte.
        n = held_bytes * $urandom_range(1, 6);
        write_length(32'(bytes_accepted + 8 + n));
        send_header(wrsp_pkg::TAG_DATA, 32'(n));
        send_noise(n);
      end
      END_NO_ROOM: begin
        write_length(32'd0);
        send_header(wrsp_pkg::TAG_DATA, 32'd4);
      end
      END_FMT_PAST: begin
        n = $urandom_range(0, 30);
        write_length(32'(bytes_accepted + 30 + n));
        send_header(wrsp_pkg::TAG_FMT, 32'(22 + n + $urandom_range(0, 3)));
      end
      END_FMT_SHORT: begin
        send_header(wrsp_pkg::TAG_FMT, 32'($urandom_range(0, 15)));
      end
      END_NOT_PCM: begin
        do length = $urandom_range(0, 3); while (length == 32'(wrsp_pkg::FMT_PCM));
        send_fmt(length == 3 ? 16'hFFFF : 16'(length), 16'd2, $urandom, 16'd16, 0);
      end
      END_BAD_DEPTH: begin
        case ($urandom_range(0, 4))
          0:       bits = 16'd0;
          1:       bits = 16'd12;
          2:       bits = 16'd40;
          3:       bits = 16'hFFFF;
          default: bits = 16'($urandom_range(1, 7));
        endcase
        send_fmt(wrsp_pkg::FMT_PCM, 16'd1, $urandom, bits, $urandom_range(0, 2));
      end
      default: begin
        write_length(32'(bytes_accepted + 100));
        send_header(wrsp_pkg::TAG_DATA, 32'($urandom_range(93, 1000)));
      end
    endcase

    // The parser is halted now: these bytes must produce nothing.
    send_noise(16);
    drain();

    $display("summary: %0d bytes streamed, %0d samples and %0d format words checked",
             bytes_accepted, samples_checked, formats_checked);
    $display("summary: file ended by %s, %0d cycles", ending.name(), cycle_count);
    if (failures == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
